// ----- rtl/brle_pkg.sv -----
// Shared types and codes for the bitmap RLE8 line decoder.
// Holds decoder phase codes and escape byte codes; no dependencies.
package brle_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] phase_t;
    typedef logic [2:0] count_t;

    // Decoder phases: position in the compressed byte stream
    localparam phase_t PH_FIRST   = 3'd0;
    localparam phase_t PH_SECOND  = 3'd1;
    localparam phase_t PH_LITERAL = 3'd2;
    localparam phase_t PH_PAD     = 3'd3;
    localparam phase_t PH_DELTA_X = 3'd4;
    localparam phase_t PH_DELTA_Y = 3'd5;

    // Second byte of an escape pair
    localparam byte_t ESC_LINE_END  = 8'd0;
    localparam byte_t ESC_IMAGE_END = 8'd1;
    localparam byte_t ESC_DELTA     = 8'd2;

endpackage

// ----- rtl/bmp_rle8_line_decoder.sv -----
// Bitmap RLE8 decoder: one compressed byte per request in, pixel groups out.
// Depends on brle_pkg (phase codes, escape codes, types).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  data     | data_valid / data_stall   | data_byte
//  result   | result_valid/result_stall | pixel_a..d, pixel_count, line_end,
//           |                           | image_end, last
//
// An input byte is decoded in the cycle it is taken. Bytes that give no
// result do not hold the input off. A byte that gives results holds the
// input off while its n pixels are loaded, one output request per cycle
// by the shared run subtractor while the output register is free; a marker
// or literal pixel gives one request. Output stalls hold the input off longer.
// Reset clears the phase and run control; no clearing pass is needed.
module bmp_rle8_line_decoder #(
    parameter int PIXEL_LANES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] pixel_a,
    output logic [7:0] pixel_b,
    output logic [7:0] pixel_c,
    output logic [7:0] pixel_d,
    output logic [2:0] pixel_count,
    output logic       line_end,
    output logic       image_end,
    output logic       last
);

    // Lanes actually used, clamped to the four output bytes
    localparam int LANES_CLAMP = (PIXEL_LANES < 1) ? 1 :
                                 ((PIXEL_LANES > 4) ? 4 : PIXEL_LANES);
    localparam brle_pkg::count_t LANES = brle_pkg::count_t'(LANES_CLAMP);

    // Decoder state
    brle_pkg::phase_t phase_reg, phase_next;
    brle_pkg::byte_t  held_reg, held_next;
    brle_pkg::byte_t  lit_left_reg, lit_left_next;
    logic             pad_reg, pad_next;

    // Run engine
    logic             busy_reg, busy_next;
    brle_pkg::byte_t  left_reg, left_next;
    brle_pkg::byte_t  run_byte_reg, run_byte_next;
    logic             le_reg, le_next;
    logic             ie_reg, ie_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    brle_pkg::byte_t  out_pix_reg [4];
    brle_pkg::count_t out_cnt_reg;
    logic             out_le_reg, out_ie_reg, out_last_reg;

    logic             accept;
    logic             slot_free;
    logic             emit;
    logic             flag;
    brle_pkg::count_t emit_cnt;
    brle_pkg::byte_t  run_rem;
    logic             emit_last;

    assign data_stall = busy_reg;
    assign accept     = data_valid && !busy_reg;
    assign slot_free  = !out_valid_reg || !result_stall;
    assign emit       = busy_reg && slot_free;
    assign flag       = le_reg || ie_reg;

    // Shared run unit: take up to LANES pixels off the remaining count
    always_comb
    begin
        if (flag)
            emit_cnt = '0;
        else if (left_reg < {5'd0, LANES})
            emit_cnt = left_reg[2:0];
        else
            emit_cnt = LANES;
        run_rem   = left_reg - {5'd0, emit_cnt};
        emit_last = flag || (run_rem == '0);
    end

    // Byte decode and run sequencing
    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        lit_left_next = lit_left_reg;
        pad_next      = pad_reg;
        busy_next     = busy_reg;
        left_next     = left_reg;
        run_byte_next = run_byte_reg;
        le_next       = le_reg;
        ie_next       = ie_reg;

        if (emit)
        begin
            left_next = run_rem;
            le_next   = 1'b0;
            ie_next   = 1'b0;
            busy_next = !emit_last;
        end

        if (accept)
        begin
            case (phase_reg)
                brle_pkg::PH_SECOND:
                begin
                    phase_next = brle_pkg::PH_FIRST;
                    if (held_reg != '0)
                    begin
                        left_next     = held_reg;
                        run_byte_next = data_byte;
                        busy_next     = 1'b1;
                    end
                    else if (data_byte == brle_pkg::ESC_LINE_END)
                    begin
                        le_next   = 1'b1;
                        left_next = '0;
                        busy_next = 1'b1;
                    end
                    else if (data_byte == brle_pkg::ESC_IMAGE_END)
                    begin
                        ie_next   = 1'b1;
                        left_next = '0;
                        busy_next = 1'b1;
                    end
                    else if (data_byte == brle_pkg::ESC_DELTA)
                        phase_next = brle_pkg::PH_DELTA_X;
                    else
                    begin
                        lit_left_next = data_byte;
                        pad_next      = data_byte[0];
                        phase_next    = brle_pkg::PH_LITERAL;
                    end
                end
                brle_pkg::PH_LITERAL:
                begin
                    left_next     = 8'd1;
                    run_byte_next = data_byte;
                    busy_next     = 1'b1;
                    if (lit_left_reg != '0)
                        lit_left_next = lit_left_reg - 8'd1;
                    if (lit_left_reg <= 8'd1)
                    begin
                        phase_next = pad_reg ? brle_pkg::PH_PAD : brle_pkg::PH_FIRST;
                        pad_next   = 1'b0;
                    end
                end
                brle_pkg::PH_PAD:     phase_next = brle_pkg::PH_FIRST;
                brle_pkg::PH_DELTA_X: phase_next = brle_pkg::PH_DELTA_Y;
                brle_pkg::PH_DELTA_Y: phase_next = brle_pkg::PH_FIRST;
                default:
                begin
                    held_next  = data_byte;
                    phase_next = brle_pkg::PH_SECOND;
                end
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (slot_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= brle_pkg::PH_FIRST;
            held_reg      <= '0;
            lit_left_reg  <= '0;
            pad_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            le_reg        <= 1'b0;
            ie_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            lit_left_reg  <= lit_left_next;
            pad_reg       <= pad_next;
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            le_reg        <= le_next;
            ie_reg        <= ie_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; unused lanes carry zero
    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
        if (emit)
        begin
            for (int j = 0; j < 4; j++)
                out_pix_reg[j] <= (3'(j) < emit_cnt) ? run_byte_reg : '0;
            out_cnt_reg  <= emit_cnt;
            out_le_reg   <= le_reg;
            out_ie_reg   <= ie_reg;
            out_last_reg <= emit_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_a      = out_pix_reg[0];
    assign pixel_b      = out_pix_reg[1];
    assign pixel_c      = out_pix_reg[2];
    assign pixel_d      = out_pix_reg[3];
    assign pixel_count  = out_cnt_reg;
    assign line_end     = out_le_reg;
    assign image_end    = out_ie_reg;
    assign last         = out_last_reg;

    // A group never carries more pixels than the lane count
    a_lane_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pixel_count <= LANES))
        else $error("pixel group wider than lane count");

    // Markers are empty and close their request
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (line_end || image_end)) |-> (pixel_count == '0 && last))
        else $error("malformed end marker");

    // An idle run engine holds no pending pixels or markers
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (left_reg == '0 && !le_reg && !ie_reg))
        else $error("run engine idle with work pending");

    // The first byte of a pair gives no result
    a_first_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == brle_pkg::PH_FIRST) |=> !busy_reg)
        else $error("first byte of pair started a run");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for bmp_rle8_line_decoder: feeds RLE8 byte streams
// and checks every pixel group against an in-bench decoder model.
// Depends on brle_pkg (phase and escape codes, types) and the decoder RTL.
module tb_top;

    localparam int PIXEL_LANES  = 4;
    localparam int LANES        = (PIXEL_LANES < 1) ? 1 :
                                  ((PIXEL_LANES > 4) ? 4 : PIXEL_LANES);
    localparam int RANDOM_BYTES = 150;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;

    // One decoded pixel group as it leaves the block
    typedef struct packed {
        brle_pkg::byte_t  px_a;
        brle_pkg::byte_t  px_b;
        brle_pkg::byte_t  px_c;
        brle_pkg::byte_t  px_d;
        brle_pkg::count_t px_count;
        logic             line_end;
        logic             image_end;
        logic             is_last;
    } pixel_group_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte = 8'd0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [7:0] pixel_c;
    logic [7:0] pixel_d;
    logic [2:0] pixel_count;
    logic       line_end;
    logic       image_end;
    logic       last;

    // Decoder model state
    brle_pkg::phase_t dec_phase = brle_pkg::PH_FIRST;
    brle_pkg::byte_t  pair_first = 8'd0;
    brle_pkg::byte_t  literal_left = 8'd0;
    logic             pad_due = 1'b0;

    pixel_group_t groups_due[$];
    int           mismatches = 0;
    int           bytes_sent = 0;
    int           burst_left = 0;
    int           cycle_count = 0;
    int           stall_mode = 0;
    int           stall_mode_left = 0;

    bmp_rle8_line_decoder #(
        .PIXEL_LANES(PIXEL_LANES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_a      (pixel_a),
        .pixel_b      (pixel_b),
        .pixel_c      (pixel_c),
        .pixel_d      (pixel_d),
        .pixel_count  (pixel_count),
        .line_end     (line_end),
        .image_end    (image_end),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Queue one expected pixel group; lanes past the count read as zero
    function automatic void push_group(input brle_pkg::byte_t px, input int cnt,
                                       input logic le, input logic ie,
                                       input logic lst);
        pixel_group_t g;
        g.px_a      = (cnt > 0) ? px : 8'd0;
        g.px_b      = (cnt > 1) ? px : 8'd0;
        g.px_c      = (cnt > 2) ? px : 8'd0;
        g.px_d      = (cnt > 3) ? px : 8'd0;
        g.px_count  = brle_pkg::count_t'(cnt);
        g.line_end  = le;
        g.image_end = ie;
        g.is_last   = lst;
        groups_due.push_back(g);
    endfunction

    // Advance the decoder model by one accepted byte
    function automatic void decode_byte(input brle_pkg::byte_t b);
        int left;
        int c;
        case (dec_phase)
            brle_pkg::PH_SECOND:
            begin
                dec_phase = brle_pkg::PH_FIRST;
                if (pair_first != 8'd0)
                begin
                    // repeat run, split into groups of LANES
                    left = pair_first;
                    while (left > 0)
                    begin
                        c = (left < LANES) ? left : LANES;
                        left -= c;
                        push_group(b, c, 1'b0, 1'b0, left == 0);
                    end
                end
                else if (b == brle_pkg::ESC_LINE_END)
                    push_group(8'd0, 0, 1'b1, 1'b0, 1'b1);
                else if (b == brle_pkg::ESC_IMAGE_END)
                    push_group(8'd0, 0, 1'b0, 1'b1, 1'b1);
                else if (b == brle_pkg::ESC_DELTA)
                    dec_phase = brle_pkg::PH_DELTA_X;
                else
                begin
                    literal_left = b;
                    pad_due      = b[0];
                    dec_phase    = brle_pkg::PH_LITERAL;
                end
            end
            brle_pkg::PH_LITERAL:
            begin
                push_group(b, 1, 1'b0, 1'b0, 1'b1);
                if (literal_left != 8'd0)
                    literal_left--;
                if (literal_left == 8'd0)
                begin
                    dec_phase = pad_due ? brle_pkg::PH_PAD : brle_pkg::PH_FIRST;
                    pad_due   = 1'b0;
                end
            end
            brle_pkg::PH_PAD:     dec_phase = brle_pkg::PH_FIRST;
            brle_pkg::PH_DELTA_X: dec_phase = brle_pkg::PH_DELTA_Y;
            brle_pkg::PH_DELTA_Y: dec_phase = brle_pkg::PH_FIRST;
            default:
            begin
                pair_first = b;
                dec_phase  = brle_pkg::PH_SECOND;
            end
        endcase
    endfunction

    // Send one byte as a request; bursts with random gaps between them
    task automatic send_byte(input brle_pkg::byte_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                data_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_repeat(input int cnt, input brle_pkg::byte_t px);
        send_byte(brle_pkg::byte_t'(cnt));
        send_byte(px);
    endtask

    task automatic send_escape(input brle_pkg::byte_t code);
        send_byte(8'd0);
        send_byte(code);
    endtask

    task automatic send_delta(input brle_pkg::byte_t dx, input brle_pkg::byte_t dy);
        send_escape(brle_pkg::ESC_DELTA);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Literal run of n random bytes, padded when n is odd
    task automatic send_literal(input int n);
        send_escape(brle_pkg::byte_t'(n));
        repeat (n) send_byte(brle_pkg::byte_t'($urandom));
        if (n % 2 == 1)
            send_byte(brle_pkg::byte_t'($urandom));
    endtask

    // Hold the sender off until every expected group has arrived
    task automatic wait_for_drain();
        data_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (groups_due.size() != 0);
    endtask

    task automatic test_repeat_runs();
        send_repeat(255, 8'hFF);
        send_repeat(1, 8'h00);
        send_repeat(6, 8'h5A);
    endtask

    task automatic test_escapes();
        send_escape(brle_pkg::ESC_LINE_END);
        send_escape(brle_pkg::ESC_IMAGE_END);
        send_delta(8'hFF, 8'h00);
    endtask

    task automatic test_literal_runs();
        // odd run with extreme pixel values and a pad byte
        send_escape(8'd3);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hAA);
        // even run, no pad
        send_literal(4);
    endtask

    // Mostly well-formed pairs with random content, some stray bytes
    task automatic test_random_stream();
        int start;
        int pick;
        int n;
        logic paused;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (!paused && bytes_sent - start >= RANDOM_BYTES / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) :
                                                  $urandom_range(1, 12);
                send_repeat(n, brle_pkg::byte_t'($urandom));
            end
            else if (pick < 45)
                send_escape(brle_pkg::ESC_LINE_END);
            else if (pick < 50)
                send_escape(brle_pkg::ESC_IMAGE_END);
            else if (pick < 60)
                send_delta(brle_pkg::byte_t'($urandom), brle_pkg::byte_t'($urandom));
            else if (pick < 90)
            begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) :
                                                   $urandom_range(3, 20);
                send_literal(n);
            end
            else
                send_byte(brle_pkg::byte_t'($urandom));
        end
    endtask

    // Receiver stall pattern: changes mode every so often
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
        end
        else
            stall_mode_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 2) == 0);
            2:       result_stall <= ((cycle_count % 5) < 2);
            default: result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check each accepted result against the oldest expected group
    always @(posedge clk)
    begin
        pixel_group_t got;
        pixel_group_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {pixel_a, pixel_b, pixel_c, pixel_d, pixel_count, line_end, image_end, last};
            if (groups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: a=%h b=%h c=%h d=%h cnt=%0d le=%b ie=%b last=%b",
                             got.px_a, got.px_b, got.px_c, got.px_d, got.px_count,
                             got.line_end, got.image_end, got.is_last);
            end
            else
            begin
                want = groups_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch exp: a=%h b=%h c=%h d=%h cnt=%0d le=%b ie=%b last=%b",
                                 want.px_a, want.px_b, want.px_c, want.px_d, want.px_count,
                                 want.line_end, want.image_end, want.is_last);
                        $display("         got: a=%h b=%h c=%h d=%h cnt=%0d le=%b ie=%b last=%b",
                                 got.px_a, got.px_b, got.px_c, got.px_d, got.px_count,
                                 got.line_end, got.image_end, got.is_last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL bmp_rle8_line_decoder");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_repeat_runs();
        test_escapes();
        test_literal_runs();
        test_random_stream();

        // let the last requests drain, then allow for the output register
        data_valid <= 1'b0;
        while (groups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && groups_due.size() == 0)
            $display("PASS bmp_rle8_line_decoder");
        else
            $display("FAIL bmp_rle8_line_decoder");
        $finish;
    end

endmodule
